// ----- src/stream_kth_largest_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// stream_kth_largest_tracker_defines.svh
// Assertion macros used by the checker file of the k-th largest tracker.
// ----------------------------------------------------------------------------
`ifndef STREAM_KTH_LARGEST_TRACKER_DEFINES_SVH
`define STREAM_KTH_LARGEST_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define SKT_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants shared by the k-th largest tracker and its cells.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int MAX_RANK_DEF = 16;
    localparam int SAMPLE_W     = 32;
    localparam int RANK_W       = 5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // control broadcast to every cell
    typedef struct packed {
        logic shift;   // a word is accepted this cycle
        logic clear;   // the word starts a new stream
    } t_cell_ctl;

    // what one cell hands to the next cell down the chain
    typedef struct packed {
        logic    take;    // cell gives up its place to a larger value
        logic    valid;   // cell holds a kept value of the current stream
        t_sample value;   // the kept value
    } t_link;

endpackage

// ----- src/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell
// One compare-and-shift cell of the sorted chain, largest values at the head.
// ----------------------------------------------------------------------------
module skt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  skt_pkg::t_cell_ctl i_ctl,
    input  skt_pkg::t_sample   i_sample,
    input  skt_pkg::t_link     i_link,
    output skt_pkg::t_link     o_link,
    output skt_pkg::t_sample   o_value_nxt
);
    import skt_pkg::*;

    t_sample r_value;
    t_sample n_value;
    logic    r_valid;
    logic    n_valid;
    logic    w_live;
    logic    w_take;

    // an empty cell, or one smaller than the sample, yields its place
    always_comb begin
        w_live  = r_valid & ~i_ctl.clear;
        w_take  = ~w_live | ($signed(r_value) < $signed(i_sample));
        n_value = w_take ? (i_link.take ? i_link.value : i_sample) : r_value;
        n_valid = w_live | i_link.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= n_value;
        end
    end

    assign o_link      = '{take: w_take, valid: w_live, value: r_value};
    assign o_value_nxt = n_value;

endmodule

// ----- src/stream_kth_largest_tracker.sv -----
// ----------------------------------------------------------------------------
// stream_kth_largest_tracker - running k-th largest value of a signed stream
// A result word is registered in the cycle after its sample word is taken.
// Throughput: one word per cycle while the result sink keeps up; every cell compares and shifts in parallel.
// Reset (synchronous, active low) empties the chain, sets rank_k to 1.
// ----------------------------------------------------------------------------
module stream_kth_largest_tracker #(
    parameter int MAX_RANK = skt_pkg::MAX_RANK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: rank_k
    input  logic                        i_cfg_we,
    input  logic [skt_pkg::RANK_W-1:0]  i_cfg_wdata,
    // sample stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] sample_value
    input  logic                        s_axis_tuser,   // [0] stream_start
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [31:0] kth_value
    output logic                        m_axis_tuser    // [0] kth_valid
);
    import skt_pkg::*;

    // count saturates at MAX_RANK + 1, so it needs room for that value
    localparam int CNT_W = $clog2(MAX_RANK + 2);
    localparam int KW    = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    logic [RANK_W-1:0] r_rank_k;
    logic [CNT_W-1:0]  r_items_seen;
    logic [CNT_W-1:0]  n_items_seen;
    logic [CNT_W-1:0]  w_items_base;

    logic              r_out_valid;
    t_sample           r_kth_value;
    logic              r_kth_valid;

    logic              w_accept;
    t_cell_ctl         w_ctl;
    t_sample           w_sample;
    t_link             w_link [MAX_RANK+1];
    t_sample           w_next_val [MAX_RANK];

    logic [KW-1:0]     w_rank_ext;
    logic [KW-1:0]     w_k_eff;
    logic [IDX_W-1:0]  w_sel;
    t_sample           w_kth;
    logic              w_kth_ok;

    // take a new word whenever the output register is free or being drained
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_sample      = s_axis_tdata;
    assign w_ctl         = '{shift: w_accept, clear: s_axis_tuser};

    // rank register: written directly, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_k <= RANK_W'(1);
        end else if (i_cfg_we) begin
            r_rank_k <= i_cfg_wdata;
        end
    end

    // clamp rank into 1..MAX_RANK
    always_comb begin
        w_rank_ext = KW'(r_rank_k);
        if (w_rank_ext == '0) begin
            w_k_eff = KW'(1);
        end else if (w_rank_ext > KW'(MAX_RANK)) begin
            w_k_eff = KW'(MAX_RANK);
        end else begin
            w_k_eff = w_rank_ext;
        end
        w_sel = IDX_W'(w_k_eff - KW'(1));
    end

    // items seen in this stream, restarted by a stream start word
    always_comb begin
        w_items_base = s_axis_tuser ? '0 : r_items_seen;
        if (w_items_base == CNT_W'(MAX_RANK + 1)) begin
            n_items_seen = w_items_base;
        end else begin
            n_items_seen = w_items_base + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items_seen <= '0;
        end else if (w_accept) begin
            r_items_seen <= n_items_seen;
        end
    end

    // head of the chain: never yields, always valid, carries the sample
    assign w_link[0] = '{take: 1'b0, valid: 1'b1, value: w_sample};

    // sorted chain, largest kept value in cell 0
    for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
        skt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample    (w_sample),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1]),
            .o_value_nxt (w_next_val[g])
        );
    end

    // pick the k-th cell from the chain's next contents
    always_comb begin
        w_kth = '0;
        for (int i = 0; i < MAX_RANK; i++) begin
            if (IDX_W'(i) == w_sel) begin
                w_kth = w_next_val[i];
            end
        end
        w_kth_ok = KW'(n_items_seen) > w_k_eff;
    end

    // output register: hold the word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // drop the value to zero while the rank is not yet reached
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kth_value <= w_kth_ok ? w_kth : '0;
            r_kth_valid <= w_kth_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_kth_value;
    assign m_axis_tuser  = r_kth_valid;

endmodule

// ----- src/skt_checker.sv -----
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks on the k-th largest tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "stream_kth_largest_tracker_defines.svh"

module skt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // an unreached rank reports zero
    `SKT_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0, "kth_value not zero while kth_valid is low")

    // a taken word yields a result word on the next cycle
    `SKT_ASSERT_NXT(a_accept_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted word gave no result")

    // the first word of a stream can never reach any rank
    `SKT_ASSERT_NXT(a_start_invalid, s_axis_tvalid && s_axis_tready && s_axis_tuser, !m_axis_tuser, "stream start word reported a valid rank")

    // a stalled result word holds
    `SKT_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // reset empties the output register
    `SKT_ASSERT_RST(a_reset_empty, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind stream_kth_largest_tracker skt_checker u_skt_checker (.*);
